[sv/arkcs_pkg.sv]
// ----------------------------------------------------------------------------
// arkcs_pkg
// shared types, constants and channel arithmetic for the range-keyed colour
// shift pipeline
// ----------------------------------------------------------------------------
package arkcs_pkg;

  localparam int unsigned PixW     = 32;
  localparam int unsigned HitsW    = 3;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 4;
  localparam int unsigned OffChW   = 9;
  localparam int unsigned WinW     = 2 * PixW;
  localparam int unsigned OffW     = NumChan * OffChW;
  localparam int unsigned CountW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = WinW;
  localparam int unsigned MaxRules = 3;

  localparam int unsigned RuleSlotsDef = 3;

  // register indexes: count first, then window/offset pairs per rule
  localparam logic [CfgIdxW-1:0] RegRuleCount = 3'd0;
  localparam int unsigned        RegRuleBase  = 1;

  typedef struct packed {
    logic [PixW-1:0]  pix;
    logic [HitsW-1:0] hits;
  } word_t;

  typedef struct packed {
    logic            en;
    logic [WinW-1:0] window;
    logic [OffW-1:0] offset;
  } rule_cfg_t;

  // all four channels inside the inclusive min/max window
  function automatic logic in_window(logic [PixW-1:0] pix, logic [WinW-1:0] win);
    logic             ok;
    logic [ChanW-1:0] ch;
    logic [ChanW-1:0] mn;
    logic [ChanW-1:0] mx;
    ok = 1'b1;
    for (int c = 0; c < NumChan; c++) begin
      ch = pix[c*ChanW +: ChanW];
      mn = win[c*ChanW +: ChanW];
      mx = win[PixW + c*ChanW +: ChanW];
      if (ch < mn || ch > mx) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // channel plus signed offset, clamped to 0..255
  function automatic logic [ChanW-1:0] sat_add(logic [ChanW-1:0] ch,
                                               logic [OffChW-1:0] off);
    logic [ChanW+1:0] sum;
    sum = {2'b00, ch} + {off[OffChW-1], off};
    if (sum[ChanW+1]) begin
      return '0;
    end else if (sum[ChanW]) begin
      return '1;
    end
    return sum[ChanW-1:0];
  endfunction

  function automatic logic [PixW-1:0] shift_pixel(logic [PixW-1:0] pix,
                                                  logic [OffW-1:0] off);
    logic [PixW-1:0] res;
    res = '0;
    for (int c = 0; c < NumChan; c++) begin
      res[c*ChanW +: ChanW] = sat_add(pix[c*ChanW +: ChanW], off[c*OffChW +: OffChW]);
    end
    return res;
  endfunction

endpackage

[sv/arkcs_cfg.sv]
// ----------------------------------------------------------------------------
// arkcs_cfg
// configuration registers: rule count and per-rule window and offset
// ----------------------------------------------------------------------------
module arkcs_cfg #(
  parameter int unsigned RULE_SLOTS = arkcs_pkg::RuleSlotsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [arkcs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [arkcs_pkg::CfgDataW-1:0]  cfg_data_i,
  output arkcs_pkg::rule_cfg_t            rule_cfg_o [RULE_SLOTS]
);

  logic [arkcs_pkg::CountW-1:0] rule_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count_q <= '0;
    end else if (cfg_we_i && cfg_idx_i == arkcs_pkg::RegRuleCount) begin
      rule_count_q <= cfg_data_i[arkcs_pkg::CountW-1:0];
    end
  end

  for (genvar k = 0; k < RULE_SLOTS; k++) begin : g_slot
    localparam logic [arkcs_pkg::CfgIdxW-1:0] WinIdx =
      arkcs_pkg::CfgIdxW'(arkcs_pkg::RegRuleBase + 2 * k);
    localparam logic [arkcs_pkg::CfgIdxW-1:0] OffIdx =
      arkcs_pkg::CfgIdxW'(arkcs_pkg::RegRuleBase + 2 * k + 1);

    logic [arkcs_pkg::WinW-1:0] window_q;
    logic [arkcs_pkg::OffW-1:0] offset_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        window_q <= '0;
        offset_q <= '0;
      end else if (cfg_we_i) begin
        if (cfg_idx_i == WinIdx) begin
          window_q <= cfg_data_i;
        end
        if (cfg_idx_i == OffIdx) begin
          offset_q <= cfg_data_i[arkcs_pkg::OffW-1:0];
        end
      end
    end

    // a count above the slot count simply enables every slot
    assign rule_cfg_o[k].en     = rule_count_q > arkcs_pkg::CountW'(k);
    assign rule_cfg_o[k].window = window_q;
    assign rule_cfg_o[k].offset = offset_q;
  end

endmodule

[sv/arkcs_rule.sv]
// ----------------------------------------------------------------------------
// arkcs_rule
// one recolour rule as two pipeline stages: window match, then offset and
// saturate
// ----------------------------------------------------------------------------
module arkcs_rule #(
  parameter int unsigned RuleIdx = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  arkcs_pkg::rule_cfg_t cfg_i,
  input  logic                 up_valid_i,
  input  arkcs_pkg::word_t     up_word_i,
  output logic                 up_ready_o,
  output logic                 dn_valid_o,
  output arkcs_pkg::word_t     dn_word_o,
  input  logic                 dn_ready_i
);

  logic             a_valid_q;
  arkcs_pkg::word_t a_word_q;
  logic             a_match_q;
  logic             a_match_d;
  logic             a_ready;

  logic             b_valid_q;
  arkcs_pkg::word_t b_word_q;
  arkcs_pkg::word_t b_word_d;
  logic             b_ready;

  assign b_ready    = !b_valid_q || dn_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign up_ready_o = a_ready;

  // match stage
  assign a_match_d = cfg_i.en && arkcs_pkg::in_window(up_word_i.pix, cfg_i.window);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && up_valid_i) begin
      a_word_q  <= up_word_i;
      a_match_q <= a_match_d;
    end
  end

  // shift stage
  always_comb begin
    b_word_d = a_word_q;
    if (a_match_q) begin
      b_word_d.pix = arkcs_pkg::shift_pixel(a_word_q.pix, cfg_i.offset);
    end
    b_word_d.hits[RuleIdx] = a_word_q.hits[RuleIdx] | a_match_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_word_q <= b_word_d;
    end
  end

  assign dn_valid_o = b_valid_q;
  assign dn_word_o  = b_word_q;

endmodule

[sv/argb_range_keyed_color_shift_top.sv]
// ----------------------------------------------------------------------------
// argb_range_keyed_color_shift_top
// ARGB8888 recolour pipeline with up to three range-keyed colour shift rules
// ----------------------------------------------------------------------------
// One pixel word is taken per cycle and one result word comes out per cycle
// while the output is not stalled. The pipeline is an input register
// followed, for each rule slot, by a window-match stage and an
// add-and-saturate stage. Rules run in index order, each on the pixel left by
// the one before. Every stage has its own valid bit and takes a new word
// whenever it is empty or its successor is moving, so bubbles are squeezed
// out and the input keeps accepting words while a finished result waits at
// the output, until the stages behind it are full. Configuration registers
// should only be written while the pipeline is empty; they feed the stages
// directly.
module argb_range_keyed_color_shift_top #(
  parameter int unsigned RULE_SLOTS = arkcs_pkg::RuleSlotsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [arkcs_pkg::PixW-1:0]      pixel_in_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [arkcs_pkg::PixW-1:0]      pixel_out_o,
  output logic [arkcs_pkg::HitsW-1:0]     rules_hit_o,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [arkcs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [arkcs_pkg::CfgDataW-1:0]  cfg_data_i
);

  arkcs_pkg::rule_cfg_t rule_cfg [RULE_SLOTS];

  // stage k feeds rule k; entry RULE_SLOTS is the output side
  logic             st_valid [RULE_SLOTS+1];
  arkcs_pkg::word_t st_word  [RULE_SLOTS+1];
  logic             st_ready [RULE_SLOTS+1];

  // input register
  logic                       in_valid_q;
  logic [arkcs_pkg::PixW-1:0] in_pix_q;
  logic                       in_ready;

  arkcs_cfg #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rule_cfg_o (rule_cfg)
  );

  // input stage takes a word when empty or when rule 0 is moving
  assign in_ready   = !in_valid_q || st_ready[0];
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_pix_q <= pixel_in_i;
    end
  end

  // hit mask starts clear; each rule only ever sets its own bit
  assign st_valid[0]     = in_valid_q;
  assign st_word[0].pix  = in_pix_q;
  assign st_word[0].hits = '0;

  for (genvar k = 0; k < RULE_SLOTS; k++) begin : g_rule
    arkcs_rule #(
      .RuleIdx (k)
    ) u_rule (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cfg_i      (rule_cfg[k]),
      .up_valid_i (st_valid[k]),
      .up_word_i  (st_word[k]),
      .up_ready_o (st_ready[k]),
      .dn_valid_o (st_valid[k+1]),
      .dn_word_o  (st_word[k+1]),
      .dn_ready_i (st_ready[k+1])
    );
  end

  // last shift stage register doubles as the output register
  assign st_ready[RULE_SLOTS] = !out_stall_i;
  assign out_valid_o          = st_valid[RULE_SLOTS];
  assign pixel_out_o          = st_word[RULE_SLOTS].pix;
  assign rules_hit_o          = st_word[RULE_SLOTS].hits;

endmodule

[sv/arkcs_checker.sv]
// ----------------------------------------------------------------------------
// arkcs_checker
// port-level checks for the recolour pipeline, bound to the top level
// ----------------------------------------------------------------------------
module arkcs_checker #(
  parameter int unsigned RULE_SLOTS = arkcs_pkg::RuleSlotsDef
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [arkcs_pkg::PixW-1:0]      pixel_out_o,
  input logic [arkcs_pkg::HitsW-1:0]     rules_hit_o
);

  localparam logic [arkcs_pkg::HitsW-1:0] SlotMask =
    arkcs_pkg::HitsW'((1 << RULE_SLOTS) - 1);

  // a stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // and does not change while it waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_out_o) && $stable(rules_hit_o))
    else $error("stalled result word changed");

  // an empty output stage means the whole pipeline can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with the output stage empty");

  // only rules that exist can report a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rules_hit_o & ~SlotMask) == '0)
    else $error("hit reported for a rule slot that is not built");

endmodule

bind argb_range_keyed_color_shift_top arkcs_checker #(
  .RULE_SLOTS (RULE_SLOTS)
) u_arkcs_checker (.*);
